[rtl/core/assert_macros.svh]
// Assertion macros shared by the plane table core.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked assertion, disabled while reset is held.
`define VFM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("plane table check failed");

// Assertion that also holds during reset.
`define VFM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("plane table check failed");

`endif

[rtl/core/vfm_pkg.sv]
// Types and fixed codes for the plane table core.
// No dependencies; used by every module of the block.
package vfm_pkg;

  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_FIND  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CACHE_HIT = 3'd0,
    ST_SCAN_HIT  = 3'd1,
    ST_NEW_PLANE = 3'd2,
    ST_FULL      = 3'd3,
    ST_DONE      = 3'd4
  } status_t;

  localparam logic [1:0] CFG_MAX_PLANES   = 2'd0;
  localparam logic [1:0] CFG_SCREEN_WIDTH = 2'd1;
  localparam logic [1:0] CFG_SPECIAL_MASK = 2'd2;

  localparam logic [7:0] MAX_PLANES_RST   = 8'd128;
  localparam logic [8:0] SCREEN_WIDTH_RST = 9'd320;
  localparam logic [7:0] SPECIAL_MASK_RST = 8'd255;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] height;
    logic [31:0]        texture_id;
    logic [7:0]         light;
    logic [15:0]        color;
    logic [7:0]         special;
    logic [8:0]         start_column;
    logic [8:0]         stop_column;
    logic [6:0]         start_plane;
    logic [7:0]         flat_index;
    logic               is_floor;
    logic [15:0]        column_value;
  } in_t;

  typedef struct packed {
    logic [6:0]  plane_index;
    logic [2:0]  status;
    logic [15:0] column_word;
    logic [8:0]  span_left;
    logic [8:0]  span_right;
  } out_t;

  typedef struct packed {
    logic [31:0] height;
    logic [31:0] texture;
    logic [7:0]  light;
    logic [15:0] color;
    logic [7:0]  special;
  } plane_key_t;

  typedef struct packed {
    plane_key_t  key;
    logic [7:0]  flat;
    logic        is_floor;
    logic [8:0]  left;
    logic [8:0]  right;
    logic [19:0] row_span;
  } plane_rec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_PROBE_RD,
    S_PROBE_CMP,
    S_PROBE_EVAL,
    S_SCAN_INIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SCAN_EVAL,
    S_ALLOC,
    S_FILL,
    S_RW_RD,
    S_RW_DATA,
    S_DONE
  } state_t;

endpackage

[rtl/core/vfm_match.sv]
// Shared registered compare unit: plane key equality and open-column test.
// Depends on vfm_pkg.
module vfm_match #(
  parameter logic [15:0] OPEN_MARK = 16'hFF00
) (
  input  logic                clk,
  input  logic                cmp_en,
  input  vfm_pkg::plane_key_t key_a,
  input  vfm_pkg::plane_key_t key_b,
  input  logic [15:0]         col_word,
  input  logic                col_ok,
  output logic                hit_r
);

  logic hit_nxt;

  always_comb begin
    hit_nxt = (key_a == key_b) && col_ok && (col_word == OPEN_MARK);
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

[rtl/core/vfm_store.sv]
// Plane record memory and column word memory, one write and one
// registered read port each. Depends on vfm_pkg.
module vfm_store #(
  parameter int PLANE_SLOTS    = 128,
  parameter int SCREEN_COLUMNS = 320
) (
  input  logic                                        clk,
  input  logic                                        rec_we,
  input  logic [$clog2(PLANE_SLOTS)-1:0]              rec_waddr,
  input  vfm_pkg::plane_rec_t                         rec_wdata,
  input  logic                                        rec_re,
  input  logic [$clog2(PLANE_SLOTS)-1:0]              rec_raddr,
  output vfm_pkg::plane_rec_t                         rec_rdata_r,
  input  logic                                        col_we,
  input  logic [$clog2(PLANE_SLOTS*SCREEN_COLUMNS)-1:0] col_waddr,
  input  logic [15:0]                                 col_wdata,
  input  logic                                        col_re,
  input  logic [$clog2(PLANE_SLOTS*SCREEN_COLUMNS)-1:0] col_raddr,
  output logic [15:0]                                 col_rdata_r
);

  localparam int COL_DEPTH = PLANE_SLOTS * SCREEN_COLUMNS;

  vfm_pkg::plane_rec_t rec_mem [PLANE_SLOTS];
  logic [15:0]         col_mem [COL_DEPTH];

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    if (rec_re) begin
      rec_rdata_r <= rec_mem[rec_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    if (col_re) begin
      col_rdata_r <= col_mem[col_raddr];
    end
  end

endmodule

[rtl/core/visplane_find_or_merge_core.sv]
// Plane table core: hashed find-or-merge of floor and ceiling plane records.
// Depends on vfm_pkg, vfm_store, vfm_match and assert_macros.svh.
//
// Items arrive on the in_ channel (valid/ready) and each produces exactly one
// result item on the out_ channel (valid/ready). Configuration registers are
// written through cfg_we/cfg_index/cfg_wdata; the user must do so only while
// the block is idle, as the block itself does not enforce it. One item is
// handled at a time; in_ready is high only when the sequencer is idle.
// A miss walks the stored planes one at a time through the shared compare
// unit, each plane taking a read, a compare and an evaluate step, after the
// cached plane of the hash slot, if any, was probed. A new plane then fills
// every column in use with the open mark, one column word per cycle through
// the single write port of the column memory.
// The result waits in an output register: a stalled receiver holds the result
// and the next item can still be accepted and processed; only its completion
// waits for the output register to drain.
// Synchronous reset clears the hash slot valid bits, sets the plane count to
// one, restores the configuration defaults and empties the output register.
// The plane and column memories are not cleared.
`include "assert_macros.svh"

module visplane_find_or_merge_core #(
  parameter int PLANE_SLOTS    = 128,
  parameter int SCREEN_COLUMNS = 320,
  parameter int MAX_ROWS       = 256,
  parameter int HASH_BITS      = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  vfm_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output vfm_pkg::out_t   out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [8:0]      cfg_wdata
);

  localparam int          PW        = $clog2(PLANE_SLOTS);
  localparam int          CW        = PW + 1;
  localparam int          AW        = $clog2(PLANE_SLOTS * SCREEN_COLUMNS);
  localparam int          FW        = $clog2(SCREEN_COLUMNS + 1);
  localparam int          HS        = 1 << HASH_BITS;
  localparam logic [15:0] OPEN_MARK = 16'((MAX_ROWS - 1) << 8);
  localparam logic [19:0] ROW_SPAN  = {10'h3FF, 10'(MAX_ROWS)};

  // Sequencer and item state.
  vfm_pkg::state_t       state_r, state_nxt;
  vfm_pkg::in_t          item_r, item_nxt;
  logic [7:0]            spec_r, spec_nxt;
  logic [HASH_BITS-1:0]  key_r, key_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [PW-1:0]         cand_r, cand_nxt;
  logic [CW-1:0]         scan_r, scan_nxt;
  logic [FW-1:0]         fill_r, fill_nxt;
  vfm_pkg::out_t         res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  vfm_pkg::out_t         out_data_r, out_data_nxt;
  logic [PW-1:0]         slot_r [HS];
  logic [PW-1:0]         slot_nxt [HS];
  logic [HS-1:0]         slot_valid_r, slot_valid_nxt;
  logic [7:0]            max_planes_r, max_planes_nxt;
  logic [8:0]            screen_width_r, screen_width_nxt;
  logic [7:0]            special_mask_r, special_mask_nxt;

  // Memory and compare unit connections.
  logic                  rec_we, rec_re, col_we, col_re;
  logic [PW-1:0]         rec_waddr, rec_raddr;
  vfm_pkg::plane_rec_t   rec_wdata, rec_rdata;
  logic [AW-1:0]         col_waddr, col_raddr;
  logic [15:0]           col_wdata, col_rdata;
  logic                  cmp_en, hit;

  // Derived conditions.
  vfm_pkg::plane_key_t   item_key;
  int                    fw_int, lim_int;
  logic [FW-1:0]         fw_w;
  logic                  col_ok, start_ok, plane_ok, is_full;
  logic [8:0]            new_left, new_right;
  logic [15:0]           rw_word;

  function automatic logic [HASH_BITS-1:0] hash_of(vfm_pkg::in_t it, logic [7:0] s);
    logic [31:0] k;
    k = (32'(it.height) >> 16) ^ (it.texture_id >> 2) ^ (32'(it.light) * 32'd7) ^
        32'(it.color) ^ (32'(s) << 3);
    return k[HASH_BITS-1:0];
  endfunction

  function automatic logic [AW-1:0] col_addr(logic [PW-1:0] p, logic [FW-1:0] c);
    return AW'(p) * AW'(SCREEN_COLUMNS) + AW'(c);
  endfunction

  always_comb begin
    item_key = '{height: item_r.height, texture: item_r.texture_id,
                 light: item_r.light, color: item_r.color, special: spec_r};
    fw_int   = int'(screen_width_r & 9'h1FC);
    if (fw_int > SCREEN_COLUMNS) begin
      fw_int = SCREEN_COLUMNS;
    end
    fw_w     = FW'(fw_int);
    col_ok   = int'(item_r.start_column) < fw_int;
    start_ok = int'(item_r.start_column) < SCREEN_COLUMNS;
    plane_ok = int'(item_r.start_plane) < PLANE_SLOTS;
    lim_int  = (int'(max_planes_r) > PLANE_SLOTS) ? PLANE_SLOTS : int'(max_planes_r);
    is_full  = (lim_int < 2) || (int'(count_r) > lim_int - 2);
    // Spans only ever widen.
    new_left  = (item_r.start_column < rec_rdata.left) ? item_r.start_column
                                                       : rec_rdata.left;
    new_right = (item_r.stop_column > rec_rdata.right) ? item_r.stop_column
                                                       : rec_rdata.right;
  end

  // Sequencer: next state, memory requests and result assembly.
  always_comb begin
    state_nxt        = state_r;
    item_nxt         = item_r;
    spec_nxt         = spec_r;
    key_nxt          = key_r;
    count_nxt        = count_r;
    cand_nxt         = cand_r;
    scan_nxt         = scan_r;
    fill_nxt         = fill_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    slot_nxt         = slot_r;
    slot_valid_nxt   = slot_valid_r;
    max_planes_nxt   = max_planes_r;
    screen_width_nxt = screen_width_r;
    special_mask_nxt = special_mask_r;
    rec_we           = 1'b0;
    rec_waddr        = cand_r;
    rec_wdata        = rec_rdata;
    rec_re           = 1'b0;
    rec_raddr        = cand_r;
    col_we           = 1'b0;
    col_waddr        = '0;
    col_wdata        = OPEN_MARK;
    col_re           = 1'b0;
    col_raddr        = '0;
    cmp_en           = 1'b0;
    rw_word          = '0;
    in_ready         = (state_r == vfm_pkg::S_IDLE);

    if (cfg_we) begin
      case (cfg_index)
        vfm_pkg::CFG_MAX_PLANES:   max_planes_nxt   = cfg_wdata[7:0];
        vfm_pkg::CFG_SCREEN_WIDTH: screen_width_nxt = cfg_wdata;
        vfm_pkg::CFG_SPECIAL_MASK: special_mask_nxt = cfg_wdata[7:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      vfm_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          spec_nxt = in_data.special & special_mask_r;
          key_nxt  = hash_of(in_data, in_data.special & special_mask_r);
          case (vfm_pkg::action_t'(in_data.action))
            vfm_pkg::ACT_FRAME: begin
              slot_valid_nxt = '0;
              count_nxt      = CW'(1);
              res_nxt        = '{7'd0, vfm_pkg::ST_DONE, 16'd0, 9'd0, 9'd0};
              state_nxt      = vfm_pkg::S_DONE;
            end
            vfm_pkg::ACT_FIND: state_nxt = vfm_pkg::S_CHECK;
            default:           state_nxt = vfm_pkg::S_RW_RD;
          endcase
        end
      end

      vfm_pkg::S_CHECK: begin
        if (is_full) begin
          res_nxt   = '{7'd0, vfm_pkg::ST_FULL, 16'd0, 9'd0, 9'd0};
          state_nxt = vfm_pkg::S_DONE;
        end else if (slot_valid_r[key_r]) begin
          cand_nxt  = slot_r[key_r];
          state_nxt = vfm_pkg::S_PROBE_RD;
        end else begin
          state_nxt = vfm_pkg::S_SCAN_INIT;
        end
      end

      vfm_pkg::S_PROBE_RD: begin
        rec_re    = 1'b1;
        rec_raddr = cand_r;
        col_re    = col_ok;
        col_raddr = col_ok ? col_addr(cand_r, FW'(item_r.start_column)) : '0;
        state_nxt = vfm_pkg::S_PROBE_CMP;
      end

      vfm_pkg::S_PROBE_CMP: begin
        cmp_en    = 1'b1;
        state_nxt = vfm_pkg::S_PROBE_EVAL;
      end

      vfm_pkg::S_PROBE_EVAL: begin
        if (hit) begin
          rec_we          = 1'b1;
          rec_waddr       = cand_r;
          rec_wdata.left  = new_left;
          rec_wdata.right = new_right;
          res_nxt   = '{7'(cand_r), vfm_pkg::ST_CACHE_HIT, 16'd0, new_left, new_right};
          state_nxt = vfm_pkg::S_DONE;
        end else begin
          state_nxt = vfm_pkg::S_SCAN_INIT;
        end
      end

      vfm_pkg::S_SCAN_INIT: begin
        if (int'(item_r.start_plane) + 1 >= int'(count_r)) begin
          state_nxt = vfm_pkg::S_ALLOC;
        end else begin
          scan_nxt  = CW'(int'(item_r.start_plane) + 1);
          state_nxt = vfm_pkg::S_SCAN_RD;
        end
      end

      vfm_pkg::S_SCAN_RD: begin
        cand_nxt  = scan_r[PW-1:0];
        rec_re    = 1'b1;
        rec_raddr = scan_r[PW-1:0];
        col_re    = col_ok;
        col_raddr = col_ok ? col_addr(scan_r[PW-1:0], FW'(item_r.start_column)) : '0;
        state_nxt = vfm_pkg::S_SCAN_CMP;
      end

      vfm_pkg::S_SCAN_CMP: begin
        cmp_en    = 1'b1;
        state_nxt = vfm_pkg::S_SCAN_EVAL;
      end

      vfm_pkg::S_SCAN_EVAL: begin
        if (hit) begin
          rec_we          = 1'b1;
          rec_waddr       = cand_r;
          rec_wdata.left  = new_left;
          rec_wdata.right = new_right;
          slot_nxt[key_r]       = cand_r;
          slot_valid_nxt[key_r] = 1'b1;
          res_nxt   = '{7'(cand_r), vfm_pkg::ST_SCAN_HIT, 16'd0, new_left, new_right};
          state_nxt = vfm_pkg::S_DONE;
        end else if (scan_r + CW'(1) >= count_r) begin
          state_nxt = vfm_pkg::S_ALLOC;
        end else begin
          scan_nxt  = scan_r + CW'(1);
          state_nxt = vfm_pkg::S_SCAN_RD;
        end
      end

      vfm_pkg::S_ALLOC: begin
        cand_nxt  = count_r[PW-1:0];
        rec_we    = 1'b1;
        rec_waddr = count_r[PW-1:0];
        rec_wdata = '{key: item_key, flat: item_r.flat_index, is_floor: item_r.is_floor,
                      left: item_r.start_column, right: item_r.stop_column,
                      row_span: ROW_SPAN};
        count_nxt             = count_r + CW'(1);
        slot_nxt[key_r]       = count_r[PW-1:0];
        slot_valid_nxt[key_r] = 1'b1;
        res_nxt  = '{7'(count_r), vfm_pkg::ST_NEW_PLANE, 16'd0,
                     item_r.start_column, item_r.stop_column};
        fill_nxt = '0;
        state_nxt = (fw_int == 0) ? vfm_pkg::S_DONE : vfm_pkg::S_FILL;
      end

      vfm_pkg::S_FILL: begin
        col_we    = 1'b1;
        col_waddr = col_addr(cand_r, fill_r);
        col_wdata = OPEN_MARK;
        fill_nxt  = fill_r + FW'(1);
        if (fill_r + FW'(1) == fw_w) begin
          state_nxt = vfm_pkg::S_DONE;
        end
      end

      vfm_pkg::S_RW_RD: begin
        rec_re    = plane_ok;
        rec_raddr = PW'(item_r.start_plane);
        col_re    = plane_ok && start_ok && (item_r.action == vfm_pkg::ACT_READ);
        col_raddr = (plane_ok && start_ok) ?
                    col_addr(PW'(item_r.start_plane), FW'(item_r.start_column)) : '0;
        state_nxt = vfm_pkg::S_RW_DATA;
      end

      vfm_pkg::S_RW_DATA: begin
        if (plane_ok && start_ok) begin
          if (item_r.action == vfm_pkg::ACT_WRITE) begin
            col_we    = 1'b1;
            col_waddr = col_addr(PW'(item_r.start_plane), FW'(item_r.start_column));
            col_wdata = item_r.column_value;
            rw_word   = item_r.column_value;
          end else begin
            rw_word   = col_rdata;
          end
        end
        res_nxt = '{item_r.start_plane, vfm_pkg::ST_DONE, rw_word,
                    plane_ok ? rec_rdata.left : 9'd0,
                    plane_ok ? rec_rdata.right : 9'd0};
        state_nxt = vfm_pkg::S_DONE;
      end

      vfm_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = vfm_pkg::S_IDLE;
        end
      end

      default: state_nxt = vfm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= vfm_pkg::S_IDLE;
      count_r        <= CW'(1);
      slot_valid_r   <= '0;
      out_valid_r    <= 1'b0;
      max_planes_r   <= vfm_pkg::MAX_PLANES_RST;
      screen_width_r <= vfm_pkg::SCREEN_WIDTH_RST;
      special_mask_r <= vfm_pkg::SPECIAL_MASK_RST;
    end else begin
      state_r        <= state_nxt;
      count_r        <= count_nxt;
      slot_valid_r   <= slot_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      max_planes_r   <= max_planes_nxt;
      screen_width_r <= screen_width_nxt;
      special_mask_r <= special_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    spec_r     <= spec_nxt;
    key_r      <= key_nxt;
    cand_r     <= cand_nxt;
    scan_r     <= scan_nxt;
    fill_r     <= fill_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    slot_r     <= slot_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  vfm_store #(
    .PLANE_SLOTS    (PLANE_SLOTS),
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_store (
    .clk         (clk),
    .rec_we      (rec_we),
    .rec_waddr   (rec_waddr),
    .rec_wdata   (rec_wdata),
    .rec_re      (rec_re),
    .rec_raddr   (rec_raddr),
    .rec_rdata_r (rec_rdata),
    .col_we      (col_we),
    .col_waddr   (col_waddr),
    .col_wdata   (col_wdata),
    .col_re      (col_re),
    .col_raddr   (col_raddr),
    .col_rdata_r (col_rdata)
  );

  vfm_match #(
    .OPEN_MARK (OPEN_MARK)
  ) u_match (
    .clk      (clk),
    .cmp_en   (cmp_en),
    .key_a    (rec_rdata.key),
    .key_b    (item_key),
    .col_word (col_rdata),
    .col_ok   (col_ok),
    .hit_r    (hit)
  );

  // The plane count never reaches the table size and never drops below one.
  `VFM_ASSERT(a_count_range, (count_r != '0) && (int'(count_r) < PLANE_SLOTS))
  // A frame start leaves exactly the reserved entry counted.
  `VFM_ASSERT(a_frame_count,
    (in_valid && in_ready && (in_data.action == vfm_pkg::ACT_FRAME)) |=> (count_r == CW'(1)))
  // The open-mark fill never runs past the columns in use.
  `VFM_ASSERT(a_fill_bound, (state_r == vfm_pkg::S_FILL) |-> (fill_r < fw_w))
  // A result is only handed over from the completion state.
  `VFM_ASSERT_ALWAYS(a_out_source,
    (rst_n && $rose(out_valid_r)) |-> ($past(state_r) == vfm_pkg::S_DONE))

endmodule
